// ===== src/scc_pkg.sv =====
// shared types, constants and palette for the sphere coverage counter
`timescale 1ns / 1ps
package scc_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;

	localparam int RADIUS_W = 22;
	localparam logic [RADIUS_W-1:0] RADIUS_RST = 22'd1000;

	localparam int COUNT_W = 11;
	localparam int COLOR_W = 8;
	localparam int OUT_W = 40;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam int SEL_W = 4;
	localparam logic [SEL_W-1:0] PAL_SAT = 4'd9;

	localparam logic [COLOR_W-1:0] C_FULL = 8'd255;
	localparam logic [COLOR_W-1:0] C_HI = 8'd237;
	localparam logic [COLOR_W-1:0] C_ORANGE = 8'd130;
	localparam logic [COLOR_W-1:0] C_AMBER = 8'd213;
	localparam logic [COLOR_W-1:0] C_LIME = 8'd91;
	localparam logic [COLOR_W-1:0] C_AQUA = 8'd174;
	localparam logic [COLOR_W-1:0] C_CYAN = 8'd229;
	localparam logic [COLOR_W-1:0] C_DEEP = 8'd99;
	localparam logic [COLOR_W-1:0] C_NONE = 8'd0;

	typedef struct packed {
		logic clear;
		logic load;
		logic start;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic held_zero;
		logic last_idx;
		logic busy;
		logic out_full;
	} sts_t;

	// returns {red, green, blue}
	function automatic logic [3*COLOR_W-1:0] pal_color(input logic [SEL_W-1:0] sel);
		logic [3*COLOR_W-1:0] rgb;
		case (sel)
			4'd0: rgb = {C_FULL, C_FULL, C_FULL};
			4'd1: rgb = {C_HI, C_NONE, C_NONE};
			4'd2: rgb = {C_HI, C_ORANGE, C_NONE};
			4'd3: rgb = {C_HI, C_AMBER, C_NONE};
			4'd4: rgb = {C_LIME, C_HI, C_NONE};
			4'd5: rgb = {C_NONE, C_HI, C_AQUA};
			4'd6: rgb = {C_NONE, C_CYAN, C_HI};
			4'd7: rgb = {C_NONE, C_AQUA, C_HI};
			4'd8: rgb = {C_NONE, C_DEEP, C_HI};
			default: rgb = {C_HI, C_NONE, C_HI};
		endcase
		return rgb;
	endfunction

endpackage

// ===== src/sphere_coverage_counter.sv =====
// top level of the sphere coverage counter
//
// channel   dir   handshake             payload
// s_*       in    s_tvalid / s_tready   s_tuser kind, s_tdata pos_x, pos_y, pos_z
// m_*       out   m_tvalid / m_tready   m_tdata hit_count, red, green, blue
// cfg_*     in    cfg_valid / cfg_ready cfg_data radius
//
// clear and load act when accepted; a query walks every point held (an empty table skips the walk),
// and the next request can be accepted in the same cycle that the result turns valid;
// the walk reads one stored point per cycle from the single-port table, then a
// five-stage distance pipeline drains before the result is registered
// reset clears the point count, the hit count and the result valid flag and sets radius to 1000; no clearing pass
// a waiting result does not block new requests, only the next query completion
`timescale 1ns / 1ps
module sphere_coverage_counter #(
	parameter int MAX_POINTS = scc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// pos_x, pos_y, pos_z, zero fill
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]      s_tdata,
	// kind
	input  logic [scc_pkg::KIND_W-1:0]             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// hit_count, red, green, blue, zero fill
	output logic [scc_pkg::OUT_W-1:0]              m_tdata,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [scc_pkg::RADIUS_W-1:0]           cfg_data
);
	import scc_pkg::*;

	localparam int DW = ((3 * COORD_BITS + 7) / 8) * 8;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	scc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	scc_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS),
		.DW         (DW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== src/scc_ctrl.sv =====
// controller state machine for the sphere coverage counter
`timescale 1ns / 1ps
module scc_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [scc_pkg::KIND_W-1:0] s_tuser,
	input  scc_pkg::sts_t              sts,
	output scc_pkg::cmd_t              cmd
);
	import scc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_WALK = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nx;
	logic       acc;

	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.clear = acc && (s_tuser == KIND_CLEAR);
				cmd.load = acc && (s_tuser == KIND_LOAD);
				cmd.start = acc && (s_tuser == KIND_QUERY);
				if (cmd.start) begin
					state_nx = sts.held_zero ? ST_DONE : ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.issue = 1'b1;
				if (sts.last_idx) begin
					state_nx = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.busy) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.finish = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== src/scc_datapath.sv =====
// point table, distance pipeline, hit counter and result register
`timescale 1ns / 1ps
module scc_datapath #(
	parameter int MAX_POINTS = scc_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = scc_pkg::COORD_BITS_DEF,
	parameter int DW = 72
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scc_pkg::cmd_t                cmd,
	output scc_pkg::sts_t                sts,
	input  logic [DW-1:0]                s_tdata,
	input  logic                         cfg_valid,
	input  logic [scc_pkg::RADIUS_W-1:0] cfg_data,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [scc_pkg::OUT_W-1:0]    m_tdata
);
	import scc_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int PW = 3 * COORD_BITS;
	localparam int DIFW = COORD_BITS + 1;
	localparam int CMPW = (DIFW > RADIUS_W) ? DIFW : RADIUS_W;
	localparam int SQW = 2 * RADIUS_W;
	localparam int SUMW = SQW + 2;
	localparam int CEW = CW + SEL_W;

	logic [PW-1:0]          mem [MAX_POINTS];
	logic [RADIUS_W-1:0]    radius_q;
	logic [SQW-1:0]         r2_q;
	logic [PW-1:0]          smp_q;
	logic [CW-1:0]          held_q;
	logic [CW-1:0]          idx_q;
	logic [CW-1:0]          count_q;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [PW-1:0]          rd_s1;
	logic signed [DIFW-1:0] diff_s2 [3];
	logic [DIFW-1:0]        mag [3];
	logic [RADIUS_W-1:0]    abs_s3 [3];
	logic                   out_s3, out_s4, out_s5;
	logic [SQW-1:0]         sq_s4 [3];
	logic [SUMW-1:0]        sum_s5;
	logic                   box_out;
	logic [CEW-1:0]         cnt_e;
	logic [SEL_W-1:0]       sel;
	logic [3*COLOR_W-1:0]   rgb;
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	// request path: table writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.load && (held_q < CW'(MAX_POINTS))) begin
			mem[held_q[AW-1:0]] <= s_tdata[PW-1:0];
		end
		if (cmd.issue) begin
			rd_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			held_q <= '0;
			idx_q <= '0;
			count_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radius_q <= cfg_data;
			end
			if (cmd.clear) begin
				held_q <= '0;
			end else if (cmd.load && (held_q < CW'(MAX_POINTS))) begin
				held_q <= held_q + 1'b1;
			end
			if (cmd.start) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.start) begin
				count_q <= '0;
			end else if (v_s5 && !out_s5 && (sum_s5 <= SUMW'(r2_q))) begin
				count_q <= count_q + 1'b1;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		box_out = 1'b0;
		for (int j = 0; j < 3; j++) begin
			mag[j] = diff_s2[j][DIFW-1] ? DIFW'(-diff_s2[j]) : DIFW'(diff_s2[j]);
			if (CMPW'(mag[j]) > CMPW'(radius_q)) begin
				box_out = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			smp_q <= s_tdata[PW-1:0];
			r2_q <= SQW'(radius_q) * SQW'(radius_q);
		end
		for (int j = 0; j < 3; j++) begin
			diff_s2[j] <= $signed({rd_s1[(j+1)*COORD_BITS-1], rd_s1[j*COORD_BITS +: COORD_BITS]})
				- $signed({smp_q[(j+1)*COORD_BITS-1], smp_q[j*COORD_BITS +: COORD_BITS]});
			abs_s3[j] <= RADIUS_W'(mag[j]);
			sq_s4[j] <= SQW'(abs_s3[j]) * SQW'(abs_s3[j]);
		end
		out_s3 <= box_out;
		out_s4 <= out_s3;
		out_s5 <= out_s4;
		sum_s5 <= SUMW'(sq_s4[0]) + SUMW'(sq_s4[1]) + SUMW'(sq_s4[2]);
		if (cmd.finish) begin
			m_tdata_q <= {(OUT_W - COUNT_W - 3 * COLOR_W)'(0),
				rgb[COLOR_W-1:0], rgb[2*COLOR_W-1:COLOR_W],
				rgb[3*COLOR_W-1:2*COLOR_W], COUNT_W'(count_q)};
		end
	end

	// palette select saturates at nine
	assign cnt_e = CEW'(count_q);
	assign sel = (cnt_e >= CEW'(PAL_SAT)) ? PAL_SAT : SEL_W'(cnt_e);
	assign rgb = pal_color(sel);

	assign sts.held_zero = (held_q == '0);
	assign sts.last_idx = (CW'(idx_q + 1'b1) == held_q);
	assign sts.busy = v_s1 || v_s2 || v_s3 || v_s4 || v_s5;
	assign sts.out_full = m_tvalid_q && !m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

`ifndef SYNTHESIS
	a_issue_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (idx_q < held_q))
		else $error("read issued beyond loaded points");
	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !sts.busy)
		else $error("result taken while pipeline busy");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start || cmd.load || cmd.clear) |-> (!sts.busy && !cmd.issue))
		else $error("request accepted during a walk");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (count_q <= held_q))
		else $error("hit count exceeds table size");
`endif

endmodule

// ===== test/tb_sphere_coverage_counter.sv =====
// self-checking testbench for the sphere coverage counter
`timescale 1ns / 1ps
module tb_sphere_coverage_counter;
	import scc_pkg::*;

	localparam int MAX_PTS = MAX_POINTS_DEF;
	localparam int CB = COORD_BITS_DEF;
	localparam int DATA_W = ((3*CB+7)/8)*8;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE = 16;
	localparam int END_SETTLE = 64;
	localparam int LONG_HOLD = 600;
	localparam longint COORD_TOP = 64'sd8388607;

	// red, green, blue from the highest byte down
	localparam logic [3*COLOR_W-1:0] PALETTE [10] = '{
		{8'd255, 8'd255, 8'd255},
		{8'd237, 8'd0, 8'd0},
		{8'd237, 8'd130, 8'd0},
		{8'd237, 8'd213, 8'd0},
		{8'd91, 8'd237, 8'd0},
		{8'd0, 8'd237, 8'd174},
		{8'd0, 8'd229, 8'd237},
		{8'd0, 8'd174, 8'd237},
		{8'd0, 8'd99, 8'd237},
		{8'd237, 8'd0, 8'd237}
	};

	typedef enum int {
		TRAFFIC_FREE,
		TRAFFIC_SENDER_GAPS,
		TRAFFIC_RECEIVER_STALLS,
		TRAFFIC_BOTH
	} traffic_mode_t;

	typedef struct {
		logic [COUNT_W-1:0] hits;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} coverage_result_t;

	class coverage_scoreboard;
		logic [RADIUS_W-1:0] radius;
		logic signed [CB-1:0] xs [MAX_PTS];
		logic signed [CB-1:0] ys [MAX_PTS];
		logic signed [CB-1:0] zs [MAX_PTS];
		int held;
		coverage_result_t pending_q [$];
		int errors;

		function new();
			radius = RADIUS_RST;
			held = 0;
			errors = 0;
		endfunction

		static function longint unsigned abs_gap(logic signed [CB-1:0] a,
			logic signed [CB-1:0] b);
			longint d;
			d = longint'(a) - longint'(b);
			return (d < 0) ? longint'(-d) : longint'(d);
		endfunction

		function void note_request(logic [KIND_W-1:0] kind, logic signed [CB-1:0] x,
			logic signed [CB-1:0] y, logic signed [CB-1:0] z);
			longint unsigned r, dx, dy, dz;
			int hits;
			coverage_result_t res;
			r = radius;
			case (kind)
				KIND_CLEAR: held = 0;
				KIND_LOAD: begin
					if (held < MAX_PTS) begin
						xs[held] = x;
						ys[held] = y;
						zs[held] = z;
						held++;
					end
				end
				KIND_QUERY: begin
					hits = 0;
					for (int i = 0; i < held; i++) begin
						dx = abs_gap(xs[i], x);
						dy = abs_gap(ys[i], y);
						dz = abs_gap(zs[i], z);
						if (dx <= r && dy <= r && dz <= r && dx*dx + dy*dy + dz*dz <= r*r)
							hits++;
					end
					res.hits = hits[COUNT_W-1:0];
					{res.red, res.green, res.blue} = PALETTE[(hits > 9) ? 9 : hits];
					pending_q.push_back(res);
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, seen);
				errors++;
			end
		endfunction

		function void check_result(coverage_result_t got);
			coverage_result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual hit_count %0d",
					$time, got.hits);
				errors++;
			end else begin
				want = pending_q.pop_front();
				compare_field("hit_count", want.hits, got.hits);
				compare_field("red", want.red, got.red);
				compare_field("green", want.green, got.green);
				compare_field("blue", want.blue, got.blue);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// pos_x, pos_y, pos_z, zero fill
	logic [DATA_W-1:0] s_tdata = '0;
	// kind
	logic [KIND_W-1:0] s_tuser = KIND_CLEAR;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// hit_count, red, green, blue, zero fill
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [RADIUS_W-1:0] cfg_data = '0;

	coverage_scoreboard sb;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_req = 0;

	sphere_coverage_counter dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	always @(posedge clk) begin
		coverage_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.hits = m_tdata[COUNT_W-1:0];
			got.red = m_tdata[COUNT_W +: COLOR_W];
			got.green = m_tdata[COUNT_W+COLOR_W +: COLOR_W];
			got.blue = m_tdata[COUNT_W+2*COLOR_W +: COLOR_W];
			sb.check_result(got);
		end
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [CB-1:0] near(longint c, longint spread);
		return CB'(c + (longint'($urandom_range(0, 32'(2*spread))) - spread));
	endfunction

	task automatic set_mode(traffic_mode_t mode);
		case (mode)
			TRAFFIC_FREE: begin
				send_idle = 0;
				recv_stall = 0;
			end
			TRAFFIC_SENDER_GAPS: begin
				send_idle = 63;
				recv_stall = 0;
			end
			TRAFFIC_RECEIVER_STALLS: begin
				send_idle = 0;
				recv_stall = 63;
			end
			default: begin
				send_idle = 26;
				recv_stall = 26;
			end
		endcase
	endtask

	task automatic send_item(logic [KIND_W-1:0] kind, logic [CB-1:0] x, logic [CB-1:0] y,
		logic [CB-1:0] z);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(DATA_W-3*CB){1'b0}}, z, y, x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_request(kind, x, y, z);
	endtask

	task automatic wait_idle(int settle);
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_radius(logic [RADIUS_W-1:0] r);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.radius = r;
	endtask

	// clustered load and query runs around a random center, with some noise
	task automatic run_sessions(int budget);
		int sent;
		int n_load;
		int n_query;
		logic [KIND_W-1:0] kind;
		logic signed [CB-1:0] cx, cy, cz;
		longint rr, spread;
		sent = 0;
		rr = sb.radius;
		while (sent < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				kind = KIND_W'($urandom_range(0, 3));
				send_item(kind, CB'($urandom), CB'($urandom), CB'($urandom));
				if (kind != KIND_UNUSED)
					sent++;
			end else begin
				if (sb.held > 40 || $urandom_range(0, 2) == 0) begin
					send_item(KIND_CLEAR, CB'($urandom), CB'($urandom), CB'($urandom));
					sent++;
				end
				case ($urandom_range(0, 3))
					0: spread = 0;
					1: spread = rr/2 + 1;
					2: spread = rr + rr/2 + 2;
					default: spread = 4*rr + 8;
				endcase
				if (spread > COORD_TOP)
					spread = COORD_TOP;
				cx = CB'($urandom);
				cy = CB'($urandom);
				cz = CB'($urandom);
				n_load = $urandom_range(0, 14);
				n_query = $urandom_range(1, 4);
				repeat (n_load)
					send_item(KIND_LOAD, near(cx, spread), near(cy, spread), near(cz, spread));
				repeat (n_query)
					send_item(KIND_QUERY, near(cx, spread), near(cy, spread), near(cz, spread));
				sent += n_load + n_query;
			end
		end
	endtask

	task automatic run_phase(logic [RADIUS_W-1:0] r, traffic_mode_t mode, int budget,
		bit squeeze);
		wait_idle(SETTLE);
		write_radius(r);
		set_mode(mode);
		if (squeeze)
			hold_req++;
		run_sessions(budget);
	endtask

	initial begin
		logic [CB-1:0] top;
		logic [CB-1:0] bottom;
		top = 24'h7FFFFF;
		bottom = 24'h800000;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset radius of 1000: empty table, boundaries, extremes, unused kind
		set_mode(TRAFFIC_FREE);
		send_item(KIND_QUERY, 0, 0, 0);
		send_item(KIND_UNUSED, '1, '1, '1);
		send_item(KIND_LOAD, 0, 0, 0);
		send_item(KIND_LOAD, 1000, 0, 0);
		send_item(KIND_LOAD, 1001, 0, 0);
		send_item(KIND_LOAD, 0, -1000, 0);
		send_item(KIND_LOAD, 600, 600, 600);
		send_item(KIND_LOAD, 577, 577, 577);
		send_item(KIND_LOAD, bottom, bottom, bottom);
		send_item(KIND_LOAD, top, top, top);
		send_item(KIND_QUERY, 0, 0, 0);
		send_item(KIND_QUERY, 1000, 0, 0);
		send_item(KIND_QUERY, top, top, top);
		send_item(KIND_QUERY, bottom, bottom, bottom);
		send_item(KIND_QUERY, top, bottom, top);
		send_item(KIND_CLEAR, top, top, top);
		send_item(KIND_QUERY, 0, 0, 0);
		send_item(KIND_UNUSED, 0, 0, 0);

		run_phase(0, TRAFFIC_SENDER_GAPS, 60, 1'b0);
		run_phase(22'h3FFFFF, TRAFFIC_RECEIVER_STALLS, 60, 1'b0);
		run_phase(1, TRAFFIC_BOTH, 60, 1'b0);
		run_phase(1000, TRAFFIC_FREE, 60, 1'b1);
		run_phase(RADIUS_W'($urandom_range(0, 4194303)), TRAFFIC_SENDER_GAPS, 60, 1'b0);
		run_phase(RADIUS_W'($urandom_range(2, 5000)), TRAFFIC_RECEIVER_STALLS, 60, 1'b0);
		run_phase(250000, TRAFFIC_BOTH, 60, 1'b0);
		run_phase(RADIUS_W'($urandom_range(0, 4194303)), TRAFFIC_FREE, 60, 1'b0);

		run_phase(RADIUS_W'($urandom_range(0, 4194303)), TRAFFIC_BOTH, 30, 1'b0);
		run_phase(22'h3FFFFF, TRAFFIC_SENDER_GAPS, 20, 1'b0);

		wait_idle(END_SETTLE);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sphere_coverage_counter.f =====
src/scc_pkg.sv
src/scc_ctrl.sv
src/scc_datapath.sv
src/sphere_coverage_counter.sv
test/tb_sphere_coverage_counter.sv
